/* design/engine_fault_annunciator_macros.svh */
// Assertion macros for the engine fault annunciator.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef ENGINE_FAULT_ANNUNCIATOR_MACROS_SVH
`define ENGINE_FAULT_ANNUNCIATOR_MACROS_SVH

// Checked only while out of reset.
`define EFA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define EFA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/efa_pkg.sv */
// Shared types and constants for the engine fault annunciator.
// No dependencies.
package efa_pkg;

	localparam int unsigned IN_W      = 8;
	localparam int unsigned OUT_W     = 48;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W     = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WATER_QUAL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COOL_DELAY  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COOL_VERIFY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BUZZ_PERIOD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BUZZ_ON     = 3'd4;

	// register reset values
	localparam logic [CFG_W-1:0] WATER_QUAL_RST  = 16'd15000;
	localparam logic [CFG_W-1:0] COOL_DELAY_RST  = 16'd3000;
	localparam logic [CFG_W-1:0] COOL_VERIFY_RST = 16'd5000;
	localparam logic [CFG_W-1:0] BUZZ_PERIOD_RST = 16'd1000;
	localparam logic [CFG_W-1:0] BUZZ_ON_RST     = 16'd500;

	localparam logic [9:0] MS_PER_SEC = 10'd1000;

	typedef enum logic [1:0] {
		COOL_IDLE,
		COOL_DELAY,
		COOL_VERIFY,
		COOL_FAULT
	} cool_phase_t;

	typedef struct packed {
		logic [CFG_W-1:0] water_qualify;
		logic [CFG_W-1:0] cool_delay;
		logic [CFG_W-1:0] cool_verify;
		logic [CFG_W-1:0] buzz_period;
		logic [CFG_W-1:0] buzz_on;
	} cfg_t;

	typedef struct packed {
		logic water_alarm;
		logic disarmed_alarm;
		logic cooling_alarm;
		logic ev_water;
		logic ev_disarm;
		logic ev_cool;
		logic new_fault;
	} fault_status_t;

	typedef struct packed {
		logic        running;
		logic [31:0] total;
		logic        ev_start;
		logic        ev_stop;
	} run_status_t;

endpackage

/* design/efa_fault.sv */
// Fault qualification: water-tank low, shutoff disarmed, cooling fault.
// Depends on efa_pkg.
module efa_fault
	import efa_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  cfg_t          cfg,
	input  logic          water_low,
	input  logic          oil_pressure_ok,
	input  logic          coolant_flow_ok,
	input  logic          shutoff_armed,
	output fault_status_t status
);

	logic [15:0] water_count_q, water_count_d;
	logic        water_flag_q, water_flag_d;
	logic        disarm_flag_q, disarm_flag_d;
	cool_phase_t cool_phase_q, cool_phase_d;
	logic [15:0] cool_count_q, cool_count_d;
	logic        cool_fault_q, cool_fault_d;
	logic        ev_water, ev_disarm, ev_cool;

	always_comb begin
		water_count_d = water_count_q;
		water_flag_d  = water_flag_q;
		ev_water      = 1'b0;
		if (water_low) begin
			if (!water_flag_q) begin
				if (water_count_q != 16'hFFFF)
					water_count_d = water_count_q + 16'd1;
				if (water_count_d >= cfg.water_qualify) begin
					water_flag_d = 1'b1;
					ev_water     = 1'b1;
				end
			end
		end else begin
			water_count_d = '0;
			water_flag_d  = 1'b0;
		end
	end

	assign ev_disarm     = !shutoff_armed && !disarm_flag_q;
	assign disarm_flag_d = !shutoff_armed;

	always_comb begin
		cool_phase_d = cool_phase_q;
		cool_count_d = cool_count_q;
		cool_fault_d = cool_fault_q;
		ev_cool      = 1'b0;
		if (!coolant_flow_ok && oil_pressure_ok) begin
			case (cool_phase_q)
				COOL_IDLE: begin
					cool_phase_d = COOL_DELAY;
					cool_count_d = '0;
				end
				COOL_DELAY: begin
					if (cool_count_q >= cfg.cool_delay) begin
						cool_phase_d = COOL_VERIFY;
						cool_count_d = '0;
					end else begin
						cool_count_d = cool_count_q + 16'd1;
					end
				end
				COOL_VERIFY: begin
					if (cool_count_q != 16'hFFFF)
						cool_count_d = cool_count_q + 16'd1;
				end
				COOL_FAULT: ;
				default: ;
			endcase
			// verify may complete on its entry tick when the verify time is zero
			if (cool_phase_d == COOL_VERIFY && cool_count_d >= cfg.cool_verify) begin
				cool_phase_d = COOL_FAULT;
				if (!cool_fault_q) begin
					cool_fault_d = 1'b1;
					ev_cool      = 1'b1;
				end
			end
		end else begin
			cool_phase_d = COOL_IDLE;
			cool_count_d = '0;
			cool_fault_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			water_count_q <= '0;
			water_flag_q  <= 1'b0;
			disarm_flag_q <= 1'b0;
			cool_phase_q  <= COOL_IDLE;
			cool_count_q  <= '0;
			cool_fault_q  <= 1'b0;
		end else if (adv) begin
			water_count_q <= water_count_d;
			water_flag_q  <= water_flag_d;
			disarm_flag_q <= disarm_flag_d;
			cool_phase_q  <= cool_phase_d;
			cool_count_q  <= cool_count_d;
			cool_fault_q  <= cool_fault_d;
		end
	end

	assign status.water_alarm    = water_flag_d;
	assign status.disarmed_alarm = disarm_flag_d;
	assign status.cooling_alarm  = cool_fault_d;
	assign status.ev_water       = ev_water;
	assign status.ev_disarm      = ev_disarm;
	assign status.ev_cool        = ev_cool;
	assign status.new_fault      = ev_water || ev_disarm || ev_cool;

endmodule

/* design/efa_runtime.sv */
// Engine running state and accumulated run seconds.
// Depends on efa_pkg.
module efa_runtime
	import efa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        oil_pressure_ok,
	output run_status_t status
);

	logic        running_q, running_d;
	logic [9:0]  millis_q, millis_d;
	logic [31:0] secs_q, secs_d;
	logic [31:0] total_q, total_d;
	logic [9:0]  millis_inc;
	logic [32:0] sum;
	logic        ev_start, ev_stop;

	assign millis_inc = millis_q + 10'd1;
	assign sum        = {1'b0, total_q} + {1'b0, secs_q};

	always_comb begin
		running_d = running_q;
		millis_d  = millis_q;
		secs_d    = secs_q;
		total_d   = total_q;
		ev_start  = 1'b0;
		ev_stop   = 1'b0;
		if (oil_pressure_ok) begin
			if (!running_q) begin
				running_d = 1'b1;
				millis_d  = '0;
				secs_d    = '0;
				ev_start  = 1'b1;
			end else if (millis_inc >= MS_PER_SEC) begin
				millis_d = '0;
				if (secs_q != 32'hFFFF_FFFF)
					secs_d = secs_q + 32'd1;
			end else begin
				millis_d = millis_inc;
			end
		end else if (running_q) begin
			// partial second dropped, total saturates
			running_d = 1'b0;
			total_d   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			millis_d  = '0;
			secs_d    = '0;
			ev_stop   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			millis_q  <= '0;
			secs_q    <= '0;
			total_q   <= '0;
		end else if (adv) begin
			running_q <= running_d;
			millis_q  <= millis_d;
			secs_q    <= secs_d;
			total_q   <= total_d;
		end
	end

	assign status.running  = running_d;
	assign status.total    = total_d;
	assign status.ev_start = ev_start;
	assign status.ev_stop  = ev_stop;

endmodule

/* design/efa_buzzer.sv */
// Silence latch and buzzer pattern generator.
// Depends on efa_pkg.
module efa_buzzer
	import efa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  cfg_t cfg,
	input  logic any_fault,
	input  logic new_fault,
	input  logic silence_press,
	output logic buzz
);

	logic        silenced_q, silenced_d;
	logic [15:0] phase_q, phase_d;
	logic [15:0] period;
	logic [15:0] phase_base;
	logic [15:0] phase_inc;

	// press in the same tick as a new fault wins
	assign silenced_d = silence_press ? 1'b1 : (new_fault ? 1'b0 : silenced_q);
	assign period     = (cfg.buzz_period == '0) ? 16'd1 : cfg.buzz_period;
	assign phase_base = (phase_q >= period) ? '0 : phase_q;
	assign phase_inc  = phase_base + 16'd1;

	always_comb begin
		buzz    = 1'b0;
		phase_d = '0;
		if (any_fault && !silenced_d) begin
			buzz    = phase_base < cfg.buzz_on;
			phase_d = (phase_inc >= period) ? '0 : phase_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			silenced_q <= 1'b0;
			phase_q    <= '0;
		end else if (adv) begin
			silenced_q <= silenced_d;
			phase_q    <= phase_d;
		end
	end

endmodule

/* design/engine_fault_annunciator.sv */
// Engine fault annunciator: an accepted input passes through the input register,
// then the result register, before the result is valid. Throughput one item per cycle; the
// input side keeps accepting while the result register is full and drained.
// Stalls only when both the input stage and the result register are occupied
// and the result is not taken in that cycle.
// arst_n clears all fault, timer and run-time state and loads register defaults.
module engine_fault_annunciator
	import efa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [0] water_low, [1] oil_pressure_ok, [2] coolant_flow_ok, [3] shutoff_armed,
	// [4] silence_press, [7:5] zero
	input  logic [IN_W-1:0]      s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [0] buzzer_on, [1] warning_led, [2] water_alarm, [3] disarmed_alarm,
	// [4] cooling_alarm, [5] engine_running, [37:6] run_seconds_total,
	// [43:38] event_flags, [47:44] zero
	output logic [OUT_W-1:0]     m_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t          cfg_q;
	logic          valid_s1;
	logic [4:0]    sample_s1;
	logic          valid_s2;
	logic [OUT_W-1:0] data_s2;
	logic          adv;
	fault_status_t fault;
	run_status_t   run;
	logic          any_fault;
	logic          buzz;
	logic [5:0]    events;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.water_qualify <= WATER_QUAL_RST;
			cfg_q.cool_delay    <= COOL_DELAY_RST;
			cfg_q.cool_verify   <= COOL_VERIFY_RST;
			cfg_q.buzz_period   <= BUZZ_PERIOD_RST;
			cfg_q.buzz_on       <= BUZZ_ON_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WATER_QUAL:  cfg_q.water_qualify <= cfg_data;
				REG_COOL_DELAY:  cfg_q.cool_delay    <= cfg_data;
				REG_COOL_VERIFY: cfg_q.cool_verify   <= cfg_data;
				REG_BUZZ_PERIOD: cfg_q.buzz_period   <= cfg_data;
				REG_BUZZ_ON:     cfg_q.buzz_on       <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			sample_s1 <= s_tdata[4:0];
	end

	efa_fault u_fault (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.cfg             (cfg_q),
		.water_low       (sample_s1[0]),
		.oil_pressure_ok (sample_s1[1]),
		.coolant_flow_ok (sample_s1[2]),
		.shutoff_armed   (sample_s1[3]),
		.status          (fault)
	);

	efa_runtime u_runtime (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.oil_pressure_ok (sample_s1[1]),
		.status          (run)
	);

	assign any_fault = fault.water_alarm || fault.disarmed_alarm || fault.cooling_alarm;

	efa_buzzer u_buzzer (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.cfg           (cfg_q),
		.any_fault     (any_fault),
		.new_fault     (fault.new_fault),
		.silence_press (sample_s1[4]),
		.buzz          (buzz)
	);

	assign events = {sample_s1[4], fault.ev_cool, fault.ev_disarm, fault.ev_water,
		run.ev_stop, run.ev_start};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= 1'b1;
		else if (m_tready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			data_s2 <= {4'b0, events, run.total, run.running, fault.cooling_alarm,
				fault.disarmed_alarm, fault.water_alarm, any_fault, buzz};
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

endmodule

/* design/efa_checker.sv */
// Port-level checks on the annunciator result stream, bound to the top level.
// Depends on efa_pkg and engine_fault_annunciator_macros.svh.
`include "engine_fault_annunciator_macros.svh"

module efa_checker
	import efa_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	`EFA_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
	`EFA_ASSERT(a_led, m_tvalid |-> m_tdata[1] == (m_tdata[2] || m_tdata[3] || m_tdata[4]), "warning led mismatch")
	`EFA_ASSERT(a_buzz, m_tvalid && m_tdata[0] |-> m_tdata[1], "buzzer on with no fault")
	`EFA_ASSERT(a_start, m_tvalid && m_tdata[38] |-> m_tdata[5] && !m_tdata[39], "start event while stopped")
	`EFA_ASSERT_ALWAYS(a_rst, !arst_n |=> !m_tvalid, "result valid right after reset")

endmodule

bind engine_fault_annunciator efa_checker u_efa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
